// ===== rtl/kmpsfm_pkg.sv =====
// Shared constants, register codes and helpers for the KMP first-match core.
// No dependencies; the interfaces and the core refer to this package by scoped names.
package kmpsfm_pkg;

    // Defaults for the top-level parameters
    localparam int PATTERN_MAX_DEF = 8;
    localparam int INDEX_BITS_DEF  = 16;

    // Fixed field widths
    localparam int BYTE_BITS    = 8;
    localparam int PAT_BITS     = 64;
    localparam int LEN_BITS     = 4;
    localparam int START_BITS   = 16;
    localparam int CFG_IDX_BITS = 2;

    // Configuration register indices
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_BYTES  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LENGTH = 2'd1;

    // Pick character k of the packed pattern (byte 0 in the low bits)
    function automatic logic [BYTE_BITS-1:0] pat_byte(
        input logic [PAT_BITS-1:0] bytes,
        input logic [2:0]          k
    );
        return bytes[{k, 3'b000} +: BYTE_BITS];
    endfunction

endpackage

// ===== rtl/kmpsfm_text_if.sv =====
// Text input channel: one character word per handshake.
// Depends on kmpsfm_pkg for the field widths.
interface kmpsfm_text_if;
    logic                             valid;
    logic                             ready;
    logic [kmpsfm_pkg::BYTE_BITS-1:0] text_byte;
    logic                             first_byte;
    logic                             last_byte;

    modport source (output valid, output text_byte, output first_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input text_byte, input first_byte, input last_byte,
                    output ready);
endinterface

// ===== rtl/kmpsfm_result_if.sv =====
// Result channel: one search status word per accepted character.
// Depends on kmpsfm_pkg for the field widths.
interface kmpsfm_result_if;
    logic                              valid;
    logic                              ready;
    logic                              match_found;
    logic [kmpsfm_pkg::START_BITS-1:0] match_start;
    logic                              no_match_at_end;
    logic                              index_overflow;

    modport source (output valid, output match_found, output match_start,
                    output no_match_at_end, output index_overflow, input ready);
    modport sink   (input valid, input match_found, input match_start,
                    input no_match_at_end, input index_overflow, output ready);
endinterface

// ===== rtl/kmpsfm_cfg_if.sv =====
// Configuration write channel: register index plus write data per word.
// Depends on kmpsfm_pkg for the field widths.
interface kmpsfm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [kmpsfm_pkg::CFG_IDX_BITS-1:0] index;
    logic [kmpsfm_pkg::PAT_BITS-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/kmpsfm_fail_ram.sv =====
// Failure-link table storage: one write port, one read port, registered read.
// Depends on nothing beyond its parameters; contents are undefined until written.
module kmpsfm_fail_ram #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3,
    parameter int DATA_W = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/kmp_substring_first_match_core.sv =====
// KMP first-match search core: top level with control sequencer and datapath.
// Depends on kmpsfm_pkg, the three channel interfaces and kmpsfm_fail_ram.
//
// Usage
//   text   : one character per word, with first_byte / last_byte framing.
//   result : one status word per accepted character, held in an output register.
//   cfg    : register writes (0 = pattern bytes, 1 = pattern length); other
//            indices are ignored. Writes are taken only while no character is
//            in flight; each write rebuilds the failure table, with text held off.
// Timing
//   A character whose match extends or starts cleanly yields its result in the
//   cycle after acceptance, one word per cycle while result.ready is high and no
//   link is followed. Each failure link followed adds a table memory read, and no
//   new character is taken until it is done; the table's single read port sets this.
// Reset
//   Clears the pattern, length, matched length, text index and found flag.
//   The table memory is not cleared; with length zero it is never read.
// Back-pressure
//   The result register holds its word while result.ready is low; a new
//   character is taken only when that register is free or draining.
module kmp_substring_first_match_core #(
    parameter int PATTERN_MAX = kmpsfm_pkg::PATTERN_MAX_DEF,
    parameter int INDEX_BITS  = kmpsfm_pkg::INDEX_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    kmpsfm_text_if.sink            text,
    kmpsfm_result_if.source        result,
    kmpsfm_cfg_if.sink             cfg
);

    localparam int ADDR_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LEN_W   = kmpsfm_pkg::LEN_BITS;
    localparam int BYTE_W  = kmpsfm_pkg::BYTE_BITS;
    localparam int PAT_W   = kmpsfm_pkg::PAT_BITS;
    localparam int START_W = kmpsfm_pkg::START_BITS;
    localparam int WIDE_W  = (INDEX_BITS > START_W) ? INDEX_BITS : START_W;

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_SCAN      = 5'b00010,
        ST_BLD_START = 5'b00100,
        ST_BLD_STEP  = 5'b01000,
        ST_BLD_WAIT  = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [PAT_W-1:0]        pattern_reg, pattern_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [LEN_W-1:0]        ml_reg, ml_next;
    logic [INDEX_BITS-1:0]   idx_reg, idx_next;
    logic                    found_reg, found_next;
    logic [LEN_W-1:0]        bi_reg, bi_next;
    logic [LEN_W-1:0]        bj_reg, bj_next;
    logic                    out_valid_reg, out_valid_next;

    // held character while failure links are followed
    logic [BYTE_W-1:0]       c_reg, c_next;
    logic                    last_reg, last_next;
    logic [INDEX_BITS-1:0]   pos_reg, pos_next;

    // result payload
    logic                    res_found_reg, res_found_next;
    logic [START_W-1:0]      res_start_reg, res_start_next;
    logic                    res_nomatch_reg, res_nomatch_next;
    logic                    res_ovf_reg, res_ovf_next;

    // table memory port
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [LEN_W-1:0]        ram_wdata;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [LEN_W-1:0]        ram_rdata;

    // search datapath
    logic [LEN_W-1:0]        n_len;
    logic                    in_scan;
    logic                    found_eff;
    logic [LEN_W-1:0]        ml_eff;
    logic [INDEX_BITS-1:0]   pos_eff;
    logic [BYTE_W-1:0]       c_cur;
    logic [INDEX_BITS-1:0]   pos_cur;
    logic                    last_cur;
    logic                    active;
    logic [LEN_W-1:0]        j_cur;
    logic                    char_eq;
    logic                    need_fetch;
    logic [LEN_W-1:0]        j_fin;
    logic                    hit;
    logic                    found_after;
    logic [LEN_W-1:0]        ml_after;
    logic [INDEX_BITS-1:0]   nm1;
    logic [INDEX_BITS-1:0]   start_idx;
    logic [WIDE_W-1:0]       start_wide;
    logic                    ovf;
    logic                    in_accept;
    logic                    cfg_accept;
    logic                    fin;
    logic                    bld_eq;

    kmpsfm_fail_ram #(
        .DEPTH  (PATTERN_MAX),
        .ADDR_W (ADDR_W),
        .DATA_W (LEN_W)
    ) u_fail_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // handshakes
    assign cfg.ready  = (state_reg == ST_IDLE);
    assign text.ready = (state_reg == ST_IDLE) && !cfg.valid &&
                        (!out_valid_reg || result.ready);
    assign in_accept  = text.valid && text.ready;
    assign cfg_accept = cfg.valid && cfg.ready;

    // one KMP step: a fresh character in idle, or the held one after a link read
    always_comb
    begin
        n_len     = (len_reg > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : len_reg;
        in_scan   = (state_reg == ST_SCAN);
        found_eff = text.first_byte ? 1'b0 : found_reg;
        ml_eff    = text.first_byte ? '0 : ml_reg;
        pos_eff   = text.first_byte ? '0 : idx_reg;

        c_cur    = in_scan ? c_reg : text.text_byte;
        pos_cur  = in_scan ? pos_reg : pos_eff;
        last_cur = in_scan ? last_reg : text.last_byte;
        active   = in_scan || (!found_eff && (n_len != '0));
        j_cur    = in_scan ? ram_rdata : ((ml_eff >= n_len) ? '0 : ml_eff);

        char_eq    = (c_cur == kmpsfm_pkg::pat_byte(pattern_reg, j_cur[2:0]));
        need_fetch = active && (j_cur != '0) && !char_eq;
        j_fin      = char_eq ? (j_cur + LEN_W'(1)) : j_cur;
        hit        = active && !need_fetch && (j_fin == n_len);

        found_after = in_scan ? hit : (found_eff || hit);
        ml_after    = !active ? ml_eff : (hit ? '0 : j_fin);

        // start index, clamped at zero
        nm1        = INDEX_BITS'(n_len - LEN_W'(1));
        start_idx  = (pos_cur >= nm1) ? (pos_cur - nm1) : '0;
        start_wide = WIDE_W'(start_idx);
        ovf        = (pos_cur == '1);
    end

    assign fin    = (in_accept && !need_fetch) || (in_scan && !need_fetch);
    assign bld_eq = (kmpsfm_pkg::pat_byte(pattern_reg, bi_reg[2:0]) ==
                     kmpsfm_pkg::pat_byte(pattern_reg, bj_reg[2:0]));

    // sequencer and next-state logic
    always_comb
    begin
        state_next       = state_reg;
        pattern_next     = pattern_reg;
        len_next         = len_reg;
        ml_next          = ml_reg;
        idx_next         = idx_reg;
        found_next       = found_reg;
        bi_next          = bi_reg;
        bj_next          = bj_reg;
        c_next           = c_reg;
        last_next        = last_reg;
        pos_next         = pos_reg;
        res_found_next   = res_found_reg;
        res_start_next   = res_start_reg;
        res_nomatch_next = res_nomatch_reg;
        res_ovf_next     = res_ovf_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;
        ram_raddr        = ADDR_W'(j_cur - LEN_W'(1));

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_accept)
                begin
                    unique case (cfg.index)
                        kmpsfm_pkg::REG_PATTERN_BYTES:
                        begin
                            pattern_next = cfg.data;
                            state_next   = ST_BLD_START;
                        end
                        kmpsfm_pkg::REG_PATTERN_LENGTH:
                        begin
                            len_next   = cfg.data[LEN_W-1:0];
                            state_next = ST_BLD_START;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
                else if (in_accept)
                begin
                    idx_next  = text.last_byte ? '0 :
                                ((pos_eff == '1) ? pos_eff : (pos_eff + INDEX_BITS'(1)));
                    c_next    = text.text_byte;
                    last_next = text.last_byte;
                    pos_next  = pos_eff;
                    if (need_fetch)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!need_fetch)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_BLD_START:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = '0;
                bi_next    = LEN_W'(1);
                bj_next    = '0;
                state_next = ST_BLD_STEP;
            end
            ST_BLD_STEP:
            begin
                ram_raddr = ADDR_W'(bj_reg - LEN_W'(1));
                if (bi_reg >= n_len)
                begin
                    state_next = ST_IDLE;
                end
                else if (bld_eq)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(bi_reg);
                    ram_wdata = bj_reg + LEN_W'(1);
                    bi_next   = bi_reg + LEN_W'(1);
                    bj_next   = bj_reg + LEN_W'(1);
                end
                else if (bj_reg != '0)
                begin
                    state_next = ST_BLD_WAIT;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(bi_reg);
                    ram_wdata = '0;
                    bi_next   = bi_reg + LEN_W'(1);
                end
            end
            ST_BLD_WAIT:
            begin
                bj_next    = ram_rdata;
                state_next = ST_BLD_STEP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // finish the character: update search state and load the result word
        if (fin)
        begin
            found_next       = last_cur ? 1'b0 : found_after;
            ml_next          = last_cur ? '0 : ml_after;
            res_found_next   = hit;
            res_start_next   = hit ? start_wide[START_W-1:0] : '0;
            res_nomatch_next = last_cur && !found_after;
            res_ovf_next     = ovf;
            out_valid_next   = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pattern_reg   <= '0;
            len_reg       <= '0;
            ml_reg        <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            bi_reg        <= '0;
            bj_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pattern_reg   <= pattern_next;
            len_reg       <= len_next;
            ml_reg        <= ml_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            bi_reg        <= bi_next;
            bj_reg        <= bj_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        c_reg           <= c_next;
        last_reg        <= last_next;
        pos_reg         <= pos_next;
        res_found_reg   <= res_found_next;
        res_start_reg   <= res_start_next;
        res_nomatch_reg <= res_nomatch_next;
        res_ovf_reg     <= res_ovf_next;
    end

    assign result.valid           = out_valid_reg;
    assign result.match_found     = res_found_reg;
    assign result.match_start     = res_start_reg;
    assign result.no_match_at_end = res_nomatch_reg;
    assign result.index_overflow  = res_ovf_reg;

endmodule
